// ----- src/hbe_pkg.sv -----
// Shared types and constants of the Huffman byte encoder.
`default_nettype none
package hbe_pkg;

	// Table geometry: the last entry holds the end-of-message code.
	localparam int NUM_SYMBOLS  = 257;
	localparam int MAX_CODE_LEN = 24;
	localparam int ADDR_W       = $clog2(NUM_SYMBOLS);

	// Field widths of one input item.
	localparam int FUNC_W  = 2;
	localparam int SYM_W   = 9;
	localparam int WORD_W  = 24;
	localparam int LEN_W   = 5;

	// Accumulator widths: up to seven pending bits plus one code word.
	localparam int PEND_W  = 7;
	localparam int PCNT_W  = 3;
	localparam int ACC_W   = 32;
	localparam int NB_W    = 3;

	// Function codes of an input item.
	localparam logic [FUNC_W-1:0] FN_LOAD   = 2'd0;
	localparam logic [FUNC_W-1:0] FN_ENCODE = 2'd1;
	localparam logic [FUNC_W-1:0] FN_END    = 2'd2;

	// What an item in the packing stage does.
	typedef enum logic [1:0] {
		KIND_NOP,
		KIND_ENCODE,
		KIND_END
	} kind_t;

	// One code table entry.
	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic [LEN_W-1:0]  len;
	} entry_t;

	// A group of output bytes handed from the packer to the emitter.
	typedef struct packed {
		logic             valid;
		logic [ACC_W-1:0] bits;
		logic [NB_W-1:0]  nbytes;
		logic             last;
	} burst_t;

endpackage
`default_nettype wire

// ----- src/hbe_table.sv -----
// Code table memory with a registered read port.
`default_nettype none
module hbe_table (
	input  wire                          clk,
	input  wire                          we,
	input  wire  [hbe_pkg::ADDR_W-1:0]   waddr,
	input  hbe_pkg::entry_t              wdata,
	input  wire                          re,
	input  wire  [hbe_pkg::ADDR_W-1:0]   raddr,
	output hbe_pkg::entry_t              rdata
);

	hbe_pkg::entry_t mem_q [hbe_pkg::NUM_SYMBOLS];
	hbe_pkg::entry_t rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ----- src/hbe_pack.sv -----
// Packing stage: appends the looked-up code to the pending bits.
`default_nettype none
module hbe_pack (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 accept,
	input  hbe_pkg::kind_t      kind,
	input  wire                 hit,
	input  hbe_pkg::entry_t     rdata,
	input  wire                 emit_free,
	output wire                 busy,
	output hbe_pkg::burst_t     burst
);

	logic                        valid_s1;
	hbe_pkg::kind_t              kind_s1;
	logic                        hit_s1;
	logic [hbe_pkg::PEND_W-1:0]  pend_bits_q;
	logic [hbe_pkg::PCNT_W-1:0]  pend_cnt_q;

	logic [hbe_pkg::LEN_W-1:0]   len;
	logic [hbe_pkg::ACC_W-1:0]   mask;
	logic [hbe_pkg::ACC_W-1:0]   word;
	logic [hbe_pkg::ACC_W-1:0]   acc;
	logic [hbe_pkg::ACC_W-1:0]   rest;
	logic [hbe_pkg::LEN_W:0]     total;
	logic [hbe_pkg::NB_W-1:0]    nfull;
	logic [hbe_pkg::NB_W-1:0]    nbytes;
	logic                        is_end;
	logic                        advance;

	// Merge the code word above the pending bits.
	always_comb begin
		len    = hit_s1 ? rdata.len : '0;
		mask   = (hbe_pkg::ACC_W'(1) << len) - hbe_pkg::ACC_W'(1);
		word   = hbe_pkg::ACC_W'(rdata.word) & mask;
		acc    = hbe_pkg::ACC_W'(pend_bits_q) | (word << pend_cnt_q);
		total  = (hbe_pkg::LEN_W+1)'(pend_cnt_q) + (hbe_pkg::LEN_W+1)'(len);
		nfull  = total[hbe_pkg::NB_W+2:3];
		rest   = acc >> {nfull, 3'b000};
		is_end = (kind_s1 == hbe_pkg::KIND_END);
		nbytes = is_end ? nfull + hbe_pkg::NB_W'(1) : nfull;
	end

	// An item leaves when it has no bytes or the emitter can take them.
	assign advance = valid_s1 && ((nbytes == '0) || emit_free);
	assign busy    = valid_s1 && !advance;

	always_comb begin
		burst.valid  = advance && (nbytes != '0);
		burst.bits   = acc;
		burst.nbytes = nbytes;
		burst.last   = is_end;
	end

	// Stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			kind_s1  <= hbe_pkg::KIND_NOP;
			hit_s1   <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			kind_s1  <= kind;
			hit_s1   <= hit;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Pending bits update when an encode or end item commits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_bits_q <= '0;
			pend_cnt_q  <= '0;
		end else if (advance) begin
			case (kind_s1)
				hbe_pkg::KIND_ENCODE: begin
					pend_bits_q <= rest[hbe_pkg::PEND_W-1:0];
					pend_cnt_q  <= total[hbe_pkg::PCNT_W-1:0];
				end
				hbe_pkg::KIND_END: begin
					pend_bits_q <= '0;
					pend_cnt_q  <= '0;
				end
				default: begin
					pend_bits_q <= pend_bits_q;
					pend_cnt_q  <= pend_cnt_q;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- src/hbe_emit.sv -----
// Output stage: sends the bytes of a burst one per cycle while m_tready is high.
`default_nettype none
module hbe_emit (
	input  wire                clk,
	input  wire                arst_n,
	input  hbe_pkg::burst_t    burst,
	output wire                emit_free,
	output wire                m_tvalid,
	input  wire                m_tready,
	output wire  [7:0]         m_tdata,
	output wire                m_tlast
);

	logic [hbe_pkg::ACC_W-1:0] bits_q;
	logic [hbe_pkg::NB_W-1:0]  cnt_q;
	logic                      last_q;
	logic                      take;

	assign m_tvalid  = (cnt_q != '0);
	assign take      = m_tvalid && m_tready;
	assign emit_free = (cnt_q == '0) || ((cnt_q == hbe_pkg::NB_W'(1)) && m_tready);
	assign m_tdata   = bits_q[7:0];
	assign m_tlast   = last_q && (cnt_q == hbe_pkg::NB_W'(1));

	// Byte counter and flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			last_q <= 1'b0;
		end else if (burst.valid) begin
			cnt_q  <= burst.nbytes;
			last_q <= burst.last;
		end else if (take) begin
			cnt_q  <= cnt_q - hbe_pkg::NB_W'(1);
		end
	end

	// Byte shift register.
	always_ff @(posedge clk) begin
		if (burst.valid) begin
			bits_q <= burst.bits;
		end else if (take) begin
			bits_q <= bits_q >> 8;
		end
	end

endmodule
`default_nettype wire

// ----- src/huffman_byte_encoder_core.sv -----
// Top level of the Huffman byte encoder.
// Input items arrive on the s_ stream: tuser carries the function code (load,
// encode, end), tdata carries symbol, code word and code length. A load item
// writes one entry of the code table. An encode item
// reads the code of its byte from the table, appends it to the pending bits
// and sends every complete byte; an end item appends the end-of-message code
// and also sends the zero-padded remainder with tlast high.
// Output items leave on the m_ stream, one byte per cycle while m_tready is high,
// tlast on the final byte of a message.
// The first byte of an item passes the stage register and then the output
// register before it is presented on the m_ stream.
// Throughput: one item per cycle when items send at most one byte and the
// receiver does not stall; an item that sends several bytes (up to four for
// an end item) holds back the next item with bytes until the single-byte
// output register drains.
// When the receiver stalls, the output register and the packing stage fill
// and s_tready drops; nothing is lost.
// Reset clears the pending bits and all valid flags; the code table keeps no
// reset and each entry must be loaded before it is used.
`default_nettype none
module huffman_byte_encoder_core (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output wire         s_tready,
	input  wire  [39:0] s_tdata,   // symbol[8:0], code_word[32:9], code_length[37:33], zero
	input  wire  [1:0]  s_tuser,   // func[1:0]
	output wire         m_tvalid,
	input  wire         m_tready,
	output wire  [7:0]  m_tdata,   // out_byte[7:0]
	output wire         m_tlast
);

	logic [hbe_pkg::SYM_W-1:0]  symbol;
	logic [hbe_pkg::WORD_W-1:0] code_word;
	logic [hbe_pkg::LEN_W-1:0]  code_length;
	logic [hbe_pkg::FUNC_W-1:0] func;
	logic                       accept;
	logic                       busy;
	logic                       emit_free;
	logic                       load_ok;
	logic                       we;
	logic                       re;
	logic                       hit;
	logic [hbe_pkg::ADDR_W-1:0] raddr;
	hbe_pkg::kind_t             kind;
	hbe_pkg::entry_t            wdata;
	hbe_pkg::entry_t            rdata;
	hbe_pkg::burst_t            burst;

	assign symbol      = s_tdata[8:0];
	assign code_word   = s_tdata[32:9];
	assign code_length = s_tdata[37:33];
	assign func        = s_tuser;

	assign s_tready = !busy;
	assign accept   = s_tvalid && s_tready;

	// Decode the item and form the table access.
	always_comb begin
		load_ok = 32'(symbol) < hbe_pkg::NUM_SYMBOLS;
		wdata.word = code_word;
		if (code_length == '0) begin
			wdata.len = hbe_pkg::LEN_W'(1);
		end else if (32'(code_length) > hbe_pkg::MAX_CODE_LEN) begin
			wdata.len = hbe_pkg::LEN_W'(hbe_pkg::MAX_CODE_LEN);
		end else begin
			wdata.len = code_length;
		end
		we    = 1'b0;
		re    = 1'b0;
		hit   = 1'b0;
		kind  = hbe_pkg::KIND_NOP;
		raddr = hbe_pkg::ADDR_W'(symbol[7:0]);
		case (func)
			hbe_pkg::FN_LOAD: begin
				we = accept && load_ok;
			end
			hbe_pkg::FN_ENCODE: begin
				kind = hbe_pkg::KIND_ENCODE;
				hit  = 32'(symbol[7:0]) < hbe_pkg::NUM_SYMBOLS;
				re   = accept;
			end
			hbe_pkg::FN_END: begin
				kind  = hbe_pkg::KIND_END;
				hit   = 1'b1;
				raddr = hbe_pkg::ADDR_W'(hbe_pkg::NUM_SYMBOLS - 1);
				re    = accept;
			end
			default: begin
				kind = hbe_pkg::KIND_NOP;
			end
		endcase
	end

	hbe_table u_table (
		.clk   (clk),
		.we    (we),
		.waddr (hbe_pkg::ADDR_W'(symbol)),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	hbe_pack u_pack (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.kind      (kind),
		.hit       (hit),
		.rdata     (rdata),
		.emit_free (emit_free),
		.busy      (busy),
		.burst     (burst)
	);

	hbe_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.burst     (burst),
		.emit_free (emit_free),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule
`default_nettype wire

// ----- dv/huffman_byte_encoder_core_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the Huffman byte encoder core.
module huffman_byte_encoder_core_tb;

	localparam int CYCLE_LIMIT  = 500000;
	localparam int TAIL_CYCLES  = 20;
	localparam int RANDOM_ITEMS = 190;
	localparam int SEGMENT_LEN  = 50;
	localparam int LONG_HOLD    = 300;

	// Function code that the block ignores.
	localparam logic [hbe_pkg::FUNC_W-1:0] FN_UNUSED = 2'd3;

	// One byte of the compressed stream as it leaves the block.
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} stream_byte_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	wire         s_tready;
	logic [39:0] s_tdata  = '0;    // symbol[8:0], code_word[32:9], code_length[37:33], zero
	logic [1:0]  s_tuser  = hbe_pkg::FN_LOAD; // func[1:0]
	wire         m_tvalid;
	logic        m_tready = 1'b0;
	wire  [7:0]  m_tdata;          // out_byte[7:0]
	wire         m_tlast;

	// Predicted code table and pending bits.
	logic [hbe_pkg::WORD_W-1:0] code_word_tbl [hbe_pkg::NUM_SYMBOLS];
	logic [hbe_pkg::LEN_W-1:0]  code_len_tbl  [hbe_pkg::NUM_SYMBOLS];
	bit                         entry_loaded  [hbe_pkg::NUM_SYMBOLS];
	logic [hbe_pkg::PEND_W-1:0] pend_bits  = '0;
	logic [hbe_pkg::PCNT_W-1:0] pend_count = '0;
	stream_byte_t               expected_bytes [$];
	logic [7:0]                 loaded_bytes [$];

	int mismatches  = 0;
	int cycle_count = 0;
	bit tx_gaps_on  = 1'b1;
	bit rx_gaps_on  = 1'b1;

	// Long receiver hold: the test raises a request, the ready process counts it out.
	int rx_hold_len      = 0;
	int rx_hold_requests = 0;
	int rx_hold_served   = 0;
	int rx_stall_left    = 0;

	huffman_byte_encoder_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// Clock with a 20 ns period.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Predict the bytes that one accepted item sends, and update table and pending bits.
	task automatic pack_item(input logic [hbe_pkg::FUNC_W-1:0] fn,
			input logic [hbe_pkg::SYM_W-1:0] sym,
			input logic [hbe_pkg::WORD_W-1:0] word, input logic [hbe_pkg::LEN_W-1:0] len);
		logic [hbe_pkg::ACC_W-1:0] acc;
		int                        nbits;
		int                        idx;
		if (fn == hbe_pkg::FN_LOAD) begin
			// Loads outside the table are dropped; lengths saturate to 1..MAX_CODE_LEN.
			if (sym < hbe_pkg::NUM_SYMBOLS) begin
				code_word_tbl[sym] = word;
				code_len_tbl[sym]  = (len == 0) ? hbe_pkg::LEN_W'(1) :
					((len > hbe_pkg::MAX_CODE_LEN) ?
					hbe_pkg::LEN_W'(hbe_pkg::MAX_CODE_LEN) : len);
				entry_loaded[sym]  = 1'b1;
			end
		end else if (fn == hbe_pkg::FN_ENCODE || fn == hbe_pkg::FN_END) begin
			idx   = (fn == hbe_pkg::FN_ENCODE) ? int'(sym[7:0]) : hbe_pkg::NUM_SYMBOLS - 1;
			acc   = hbe_pkg::ACC_W'(pend_bits);
			nbits = pend_count;
			// Word bits at or above the stored length never reach the stream.
			acc   = acc | ((hbe_pkg::ACC_W'(code_word_tbl[idx]) &
				((hbe_pkg::ACC_W'(1) << code_len_tbl[idx]) - 1)) << nbits);
			nbits = nbits + code_len_tbl[idx];
			while (nbits >= 8) begin
				expected_bytes.push_back({acc[7:0], 1'b0});
				acc   = acc >> 8;
				nbits = nbits - 8;
			end
			// An end item always closes the message, even with no bits left.
			if (fn == hbe_pkg::FN_END) begin
				expected_bytes.push_back({acc[7:0], 1'b1});
				acc   = '0;
				nbits = 0;
			end
			pend_bits  = acc[hbe_pkg::PEND_W-1:0];
			pend_count = hbe_pkg::PCNT_W'(nbits);
		end
	endtask

	// Sender gap: mostly none or short, now and then long.
	function automatic int tx_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!tx_gaps_on || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Offer one item until it is accepted, predict it, then maybe idle.
	task automatic send_item(input logic [hbe_pkg::FUNC_W-1:0] fn,
			input logic [hbe_pkg::SYM_W-1:0] sym,
			input logic [hbe_pkg::WORD_W-1:0] word, input logic [hbe_pkg::LEN_W-1:0] len);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser  <= fn;
		s_tdata  <= {2'b00, len, word, sym};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pack_item(fn, sym, word, len);
		gap = tx_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Load one entry and remember byte entries that become usable.
	task automatic load_entry(input logic [hbe_pkg::SYM_W-1:0] sym,
			input logic [hbe_pkg::WORD_W-1:0] word, input logic [hbe_pkg::LEN_W-1:0] len);
		bit fresh;
		fresh = (sym < 256) && !entry_loaded[sym];
		send_item(hbe_pkg::FN_LOAD, sym, word, len);
		if (fresh)
			loaded_bytes.push_back(sym[7:0]);
	endtask

	function automatic logic [7:0] pick_loaded_byte();
		return loaded_bytes[$urandom_range(0, loaded_bytes.size() - 1)];
	endfunction

	// Mostly short codes, sometimes any length including the saturating ones.
	function automatic logic [hbe_pkg::LEN_W-1:0] rand_len();
		if ($urandom_range(0, 1) == 0)
			return hbe_pkg::LEN_W'($urandom_range(1, 8));
		return hbe_pkg::LEN_W'($urandom_range(0, 31));
	endfunction

	// Stop sending and wait until every predicted byte has arrived.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (expected_bytes.size() != 0);
	endtask

	task automatic report_mismatch(input string what, input logic [7:0] want_v,
			input logic [7:0] got_v);
		mismatches++;
		if (mismatches <= 10)
			$display("ERROR %s: expected 0x%02h, got 0x%02h", what, want_v, got_v);
	endtask

	// Saturation, ignored items, masked word bits, full drains and the empty final byte.
	task automatic test_special_cases();
		send_item(FN_UNUSED, 9'h1ff, 24'hffffff, 5'h1f);
		load_entry(9'd0, 24'hffffff, 5'd0);
		load_entry(9'd255, 24'hffffff, 5'd24);
		load_entry(9'd256, 24'ha5a5a5, 5'd31);
		load_entry(9'd300, 24'h123456, 5'd4);
		load_entry(9'd511, 24'h000000, 5'd1);
		load_entry(9'd1, 24'h000003, 5'd3);
		load_entry(9'd128, 24'hffff5a, 5'd8);
		load_entry(9'd77, 24'h5a5a5a, 5'd23);
		send_item(hbe_pkg::FN_ENCODE, 9'd0, 24'h0, 5'd0);
		send_item(hbe_pkg::FN_ENCODE, 9'd255, 24'h0, 5'd0);
		send_item(hbe_pkg::FN_ENCODE, 9'h101, 24'h0, 5'd0);
		send_item(FN_UNUSED, 9'h0aa, 24'h555555, 5'h0a);
		send_item(hbe_pkg::FN_ENCODE, 9'd128, 24'h0, 5'd0);
		send_item(hbe_pkg::FN_ENCODE, 9'd255, 24'h0, 5'd0);
		send_item(hbe_pkg::FN_END, 9'd0, 24'h0, 5'd0);
		// An 8-bit end code on an empty accumulator leaves a zero last byte.
		load_entry(9'd256, 24'hffff3c, 5'd8);
		send_item(hbe_pkg::FN_END, 9'd0, 24'h0, 5'd0);
		send_item(hbe_pkg::FN_END, 9'h1ff, 24'hffffff, 5'h1f);
		send_item(hbe_pkg::FN_ENCODE, 9'd77, 24'h0, 5'd0);
		send_item(hbe_pkg::FN_END, 9'd0, 24'h0, 5'd0);
		wait_drained();
	endtask

	// Hold the receiver off while items keep coming so the block backs up.
	task automatic test_output_backpressure();
		tx_gaps_on = 1'b0;
		rx_hold_len = LONG_HOLD;
		rx_hold_requests++;
		repeat (30)
			send_item(hbe_pkg::FN_ENCODE, {1'b0, pick_loaded_byte()}, '0, '0);
		send_item(hbe_pkg::FN_END, '0, '0, '0);
		tx_gaps_on = 1'b1;
		wait_drained();
	endtask

	// Random messages: loads, encodes, ends and ignored items, with a full drain between segments.
	task automatic test_random_messages();
		int                        done;
		int                        next_seg;
		int                        seg;
		int                        r;
		logic [hbe_pkg::SYM_W-1:0] sym;
		done     = 0;
		next_seg = 0;
		seg      = 0;
		while (done < RANDOM_ITEMS) begin
			if (done >= next_seg) begin
				wait_drained();
				tx_gaps_on = (seg % 3 != 1);
				rx_gaps_on = (seg % 3 != 1);
				seg++;
				next_seg += SEGMENT_LEN;
			end
			r = $urandom_range(0, 99);
			if (r < 14) begin
				case ($urandom_range(0, 9))
					7:       sym = hbe_pkg::SYM_W'(hbe_pkg::NUM_SYMBOLS - 1);
					8, 9:    sym = hbe_pkg::SYM_W'($urandom_range(hbe_pkg::NUM_SYMBOLS, 511));
					default: sym = hbe_pkg::SYM_W'($urandom_range(0, 255));
				endcase
				load_entry(sym, hbe_pkg::WORD_W'($urandom()), rand_len());
				if (sym < hbe_pkg::NUM_SYMBOLS)
					done++;
			end else if (r < 84) begin
				send_item(hbe_pkg::FN_ENCODE, {1'($urandom_range(0, 1)), pick_loaded_byte()},
					hbe_pkg::WORD_W'($urandom()), hbe_pkg::LEN_W'($urandom()));
				done++;
			end else if (r < 97) begin
				send_item(hbe_pkg::FN_END, hbe_pkg::SYM_W'($urandom()),
					hbe_pkg::WORD_W'($urandom()), hbe_pkg::LEN_W'($urandom()));
				done++;
			end else begin
				send_item(FN_UNUSED, hbe_pkg::SYM_W'($urandom()),
					hbe_pkg::WORD_W'($urandom()), hbe_pkg::LEN_W'($urandom()));
			end
		end
		tx_gaps_on = 1'b1;
		rx_gaps_on = 1'b1;
	endtask

	// Receiver ready: random stalls, plus the long hold on request.
	always @(posedge clk) begin
		if (rx_hold_served != rx_hold_requests) begin
			rx_hold_served = rx_hold_requests;
			rx_stall_left  = rx_hold_len;
		end
		if (rx_stall_left > 0) begin
			rx_stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if (rx_gaps_on && $urandom_range(0, 3) == 0)
				rx_stall_left = ($urandom_range(0, 15) == 0) ?
					$urandom_range(10, 40) : $urandom_range(1, 3);
		end
	end

	// Compare each accepted output byte with the oldest prediction.
	always @(posedge clk) begin : check_out
		stream_byte_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_bytes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR unexpected output byte 0x%02h, last %0b", m_tdata, m_tlast);
			end else begin
				want = expected_bytes.pop_front();
				if (m_tdata !== want.data)
					report_mismatch("out_byte", want.data, m_tdata);
				if (m_tlast !== want.last)
					report_mismatch("last", {7'd0, want.last}, {7'd0, m_tlast});
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("huffman_byte_encoder_core: mismatch");
			$finish;
		end
	end

	// Test sequence.
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_special_cases();
		test_output_backpressure();
		test_random_messages();
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("huffman_byte_encoder_core: match");
		else
			$display("huffman_byte_encoder_core: mismatch");
		$finish;
	end

endmodule
